// File: rtl/core/mapk_pkg.sv
// Package for the MAPK cascade rate evaluator: payload structs, register
// indexes and fixed constants. No dependencies.
`timescale 1ns / 1ps
package mapk_pkg;

  localparam int unsigned InW   = 25;
  localparam int unsigned CfgW  = 24;
  localparam int unsigned OutW  = 24;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;

  // Numerator of a quotient: up to 25 x 25 bits for the enzyme-substrate products.
  localparam int unsigned NumW  = InW + InW;
  // Divisor: sum of a 24 bit constant and a 25 bit concentration.
  localparam int unsigned DenW  = InW + 1;
  // Quotients fit the numerator width.
  localparam int unsigned QW    = NumW;
  // Division pipeline stages, one quotient bit each.
  localparam int unsigned DivStages = NumW;

  localparam logic [CfgW-1:0] K1Const  = 24'd655360;
  localparam logic [CfgW-1:0] Kk2Const = 24'd524288;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOS_ACT_VMAX  = 3'd0,
    REG_FB_INHIB      = 3'd1,
    REG_MOS_DEPH_VMAX = 3'd2,
    REG_MEK_KCAT      = 3'd3,
    REG_MEK_DEPH_VMAX = 3'd4,
    REG_ERK_KCAT      = 3'd5,
    REG_ERK_DEPH_VMAX = 3'd6,
    REG_SHARED_KM     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [InW-1:0] mos;
    logic [InW-1:0] mos_p;
    logic [InW-1:0] mek;
    logic [InW-1:0] mek_p;
    logic [InW-1:0] mek_pp;
    logic [InW-1:0] erk;
    logic [InW-1:0] erk_p;
    logic [InW-1:0] erk_pp;
  } mapk_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] d_mos;
    logic signed [OutW-1:0] d_mos_p;
    logic signed [OutW-1:0] d_mek;
    logic signed [OutW-1:0] d_mek_p;
    logic signed [OutW-1:0] d_mek_pp;
    logic signed [OutW-1:0] d_erk;
    logic signed [OutW-1:0] d_erk_p;
    logic signed [OutW-1:0] d_erk_pp;
  } mapk_out_t;

endpackage

// File: rtl/core/mapk_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, stall-aware.
// Depends on mapk_pkg. A zero divisor gives a zero quotient.
`timescale 1ns / 1ps
module mapk_div_pipe
  import mapk_pkg::*;
#(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 26,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  // Partial remainder never exceeds the divisor, so DW+1 bits suffice.
  logic [NW-1:0] n_q   [NW+1];
  logic [DW:0]   r_q   [NW+1];
  logic [DW-1:0] d_q   [NW+1];
  logic [SW-1:0] s_q   [NW+1];

  always_comb begin
    n_q[0] = num_i;
    r_q[0] = '0;
    d_q[0] = den_i;
    s_q[0] = side_i;
  end

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   rem_d;
    logic          bit_d;
    logic [NW-1:0] n_d;
    always_comb begin
      trial = {r_q[g], n_q[g][NW-1]} - {2'b00, d_q[g]};
      bit_d = ~trial[DW+1];
      rem_d = bit_d ? trial[DW:0] : {r_q[g][DW-1:0], n_q[g][NW-1]};
      n_d   = {n_q[g][NW-2:0], bit_d};
    end
    logic [NW-1:0] n_r;
    logic [DW:0]   r_r;
    logic [DW-1:0] d_r;
    logic [SW-1:0] s_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_r <= n_d;
        r_r <= rem_d;
        d_r <= d_q[g];
        s_r <= s_q[g];
      end
    end
    always_comb begin
      n_q[g+1] = n_r;
      r_q[g+1] = r_r;
      d_q[g+1] = d_r;
      s_q[g+1] = s_r;
    end
  end

  // With a zero divisor every trial succeeds; force zero explicitly.
  assign quo_o  = (d_q[NW] == '0) ? '0 : n_q[NW];
  assign side_o = s_q[NW];

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// File: rtl/core/mapk_cascade_rate_eval.sv
// Top level of the MAPK cascade rate evaluator (Kholodenko model, fixed point).
// Depends on mapk_pkg and mapk_div_pipe.
`timescale 1ns / 1ps
//
// Usage:
//   in_valid_i/in_ready_o/in_data_i carry one request of eight species
//   concentrations (unsigned Q9.16). out_valid_o/out_ready_i/out_data_o return
//   the eight time derivatives (signed Q8.16, saturated), one per request, in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the eight rate constants; write only
//   while idle. Every index selects one of the eight registers.
// Throughput: one request per cycle. The whole datapath is one stall-enabled
//   pipeline; it advances whenever the output slot is empty or being taken.
// Datapath: a bank of ten pipelined dividers for the Michaelis-Menten quotients,
//   then, after the catalytic multiply, one more pipelined divider for the
//   feedback quotient of the Mos activation rate.
// Reset: clears all valid bits and loads the default rate constants.
// Stall: when out_ready_i is low with a result waiting, the pipeline freezes,
//   in_ready_o drops, and nothing is lost or repeated.
module mapk_cascade_rate_eval
  import mapk_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mapk_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mapk_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned NDiv = 10;
  localparam int unsigned Lat1 = DivStages;
  localparam int unsigned CatW = CfgW + InW;

  // ---------------- configuration registers ----------------
  logic [CfgW-1:0] cfg_q [NumCfg];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_MOS_ACT_VMAX]  <= 24'd163840;
      cfg_q[REG_FB_INHIB]      <= 24'd589824;
      cfg_q[REG_MOS_DEPH_VMAX] <= 24'd16384;
      cfg_q[REG_MEK_KCAT]      <= 24'd1638;
      cfg_q[REG_MEK_DEPH_VMAX] <= 24'd49152;
      cfg_q[REG_ERK_KCAT]      <= 24'd1638;
      cfg_q[REG_ERK_DEPH_VMAX] <= 24'd32768;
      cfg_q[REG_SHARED_KM]     <= 24'd983040;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // ---------------- global stall ----------------
  logic out_valid_q;
  logic adv;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Valid bits travel in a shift line alongside the data pipeline:
  // stage A, first divider, stage B, second divider, stage C.
  localparam int unsigned TotLat = 2 * Lat1 + 3;
  logic [TotLat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TotLat-2:0], in_valid_i};
    end
  end

  // ---------------- stage A: products and divisors ----------------
  logic [NumW-1:0] num_a_q [NDiv];
  logic [DenW-1:0] den_a_q [NDiv];
  logic [InW-1:0]  erkpp_a_q;
  logic [InW-1:0]  km_ext;
  assign km_ext = {1'b0, cfg_q[REG_SHARED_KM]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // 0: v1 pre-feedback  1: v2  2..3: E*S for v3,v4  4..5: v5,v6
      // 6..7: E*S for v7,v8  8..9: v9,v10
      num_a_q[0] <= NumW'(cfg_q[REG_MOS_ACT_VMAX]) * NumW'(in_data_i.mos);
      den_a_q[0] <= {1'b0, in_data_i.mos} + {2'b0, K1Const};
      num_a_q[1] <= NumW'(cfg_q[REG_MOS_DEPH_VMAX]) * NumW'(in_data_i.mos_p);
      den_a_q[1] <= {1'b0, in_data_i.mos_p} + {2'b0, Kk2Const};
      num_a_q[2] <= NumW'({25'd0, in_data_i.mos_p} * {25'd0, in_data_i.mek});
      den_a_q[2] <= {1'b0, in_data_i.mek} + {1'b0, km_ext};
      num_a_q[3] <= NumW'({25'd0, in_data_i.mos_p} * {25'd0, in_data_i.mek_p});
      den_a_q[3] <= {1'b0, in_data_i.mek_p} + {1'b0, km_ext};
      num_a_q[4] <= NumW'(cfg_q[REG_MEK_DEPH_VMAX]) * NumW'(in_data_i.mek_pp);
      den_a_q[4] <= {1'b0, in_data_i.mek_pp} + {1'b0, km_ext};
      num_a_q[5] <= NumW'(cfg_q[REG_MEK_DEPH_VMAX]) * NumW'(in_data_i.mek_p);
      den_a_q[5] <= {1'b0, in_data_i.mek_p} + {1'b0, km_ext};
      num_a_q[6] <= NumW'({25'd0, in_data_i.mek_pp} * {25'd0, in_data_i.erk});
      den_a_q[6] <= {1'b0, in_data_i.erk} + {1'b0, km_ext};
      num_a_q[7] <= NumW'({25'd0, in_data_i.mek_pp} * {25'd0, in_data_i.erk_p});
      den_a_q[7] <= {1'b0, in_data_i.erk_p} + {1'b0, km_ext};
      num_a_q[8] <= NumW'(cfg_q[REG_ERK_DEPH_VMAX]) * NumW'(in_data_i.erk_pp);
      den_a_q[8] <= {1'b0, in_data_i.erk_pp} + {1'b0, km_ext};
      num_a_q[9] <= NumW'(cfg_q[REG_ERK_DEPH_VMAX]) * NumW'(in_data_i.erk_p);
      den_a_q[9] <= {1'b0, in_data_i.erk_p} + {1'b0, km_ext};
      erkpp_a_q  <= in_data_i.erk_pp;
    end
  end

  // ---------------- first divider bank ----------------
  logic [QW-1:0]  q1 [NDiv];
  logic [InW-1:0] erkpp_b;
  for (genvar i = 0; i < NDiv; i++) begin : g_div1
    if (i == 0) begin : g_side
      mapk_div_pipe #(.NW(NumW), .DW(DenW), .SW(InW)) u_div (
        .clk_i, .rst_ni, .en_i(adv),
        .num_i(num_a_q[i]), .den_i(den_a_q[i]), .side_i(erkpp_a_q),
        .quo_o(q1[i]), .side_o(erkpp_b)
      );
    end else begin : g_plain
      logic unused_side;
      mapk_div_pipe #(.NW(NumW), .DW(DenW), .SW(1)) u_div (
        .clk_i, .rst_ni, .en_i(adv),
        .num_i(num_a_q[i]), .den_i(den_a_q[i]), .side_i(1'b0),
        .quo_o(q1[i]), .side_o(unused_side)
      );
    end
  end

  // ---------------- stage B: catalytic multiply, feedback numerator ----------------
  // Quotient widths: mm terms stay below 2^24, E*S/(K+S) below 2^25,
  // so the catalytic terms stay below 2^33.
  localparam int unsigned RW = 33;
  logic [RW-1:0]   r_b_q [NDiv];
  logic [NumW-1:0] fb_num_b_q;
  logic [DenW-1:0] fb_den_b_q;
  logic [CatW-1:0] cat_p [4];

  always_comb begin
    cat_p[0] = CatW'(cfg_q[REG_MEK_KCAT]) * CatW'(q1[2][InW-1:0]);
    cat_p[1] = CatW'(cfg_q[REG_MEK_KCAT]) * CatW'(q1[3][InW-1:0]);
    cat_p[2] = CatW'(cfg_q[REG_ERK_KCAT]) * CatW'(q1[6][InW-1:0]);
    cat_p[3] = CatW'(cfg_q[REG_ERK_KCAT]) * CatW'(q1[7][InW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fb_num_b_q <= NumW'(q1[0][InW-1:0]) * NumW'(cfg_q[REG_FB_INHIB]);
      fb_den_b_q <= {1'b0, erkpp_b} + {2'b0, cfg_q[REG_FB_INHIB]};
      r_b_q[0] <= '0;
      r_b_q[1] <= RW'(q1[1]);
      r_b_q[2] <= RW'(cat_p[0] >> 16);
      r_b_q[3] <= RW'(cat_p[1] >> 16);
      r_b_q[4] <= RW'(q1[4]);
      r_b_q[5] <= RW'(q1[5]);
      r_b_q[6] <= RW'(cat_p[2] >> 16);
      r_b_q[7] <= RW'(cat_p[3] >> 16);
      r_b_q[8] <= RW'(q1[8]);
      r_b_q[9] <= RW'(q1[9]);
    end
  end

  // ---------------- second divider: feedback quotient ----------------
  localparam int unsigned SideW = (NDiv - 1) * RW;
  logic [SideW-1:0] side_b, side_c;
  logic [QW-1:0]    v1_c;
  for (genvar i = 1; i < NDiv; i++) begin : g_pack
    assign side_b[(i-1)*RW +: RW] = r_b_q[i];
  end

  mapk_div_pipe #(.NW(NumW), .DW(DenW), .SW(SideW)) u_fb_div (
    .clk_i, .rst_ni, .en_i(adv),
    .num_i(fb_num_b_q), .den_i(fb_den_b_q), .side_i(side_b),
    .quo_o(v1_c), .side_o(side_c)
  );

  logic unused_r0;
  assign unused_r0 = ^r_b_q[0];

  // ---------------- stage C: signed sums ----------------
  localparam int unsigned SumW = RW + 3;
  logic signed [SumW-1:0] v [NDiv];
  always_comb begin
    v[0] = SumW'(v1_c[RW-1:0]);
    for (int i = 1; i < NDiv; i++) begin
      v[i] = SumW'(side_c[(i-1)*RW +: RW]);
    end
  end

  logic signed [SumW-1:0] sum_c_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_c_q[0] <= v[1] - v[0];
      sum_c_q[1] <= v[0] - v[1];
      sum_c_q[2] <= v[5] - v[2];
      sum_c_q[3] <= v[2] - v[3] + v[4] - v[5];
      sum_c_q[4] <= v[3] - v[4];
      sum_c_q[5] <= v[9] - v[6];
      sum_c_q[6] <= v[6] - v[7] + v[8] - v[9];
      sum_c_q[7] <= v[7] - v[8];
    end
  end

  function automatic logic signed [OutW-1:0] sat(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi, lo;
    hi = SumW'(8388607);
    lo = -SumW'(8388608);
    if (x > hi) begin
      sat = 24'sd8388607;
    end else if (x < lo) begin
      sat = -24'sd8388608;
    end else begin
      sat = x[OutW-1:0];
    end
  endfunction

  // ---------------- output register ----------------
  mapk_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.d_mos    <= sat(sum_c_q[0]);
      out_q.d_mos_p  <= sat(sum_c_q[1]);
      out_q.d_mek    <= sat(sum_c_q[2]);
      out_q.d_mek_p  <= sat(sum_c_q[3]);
      out_q.d_mek_pp <= sat(sum_c_q[4]);
      out_q.d_erk    <= sat(sum_c_q[5]);
      out_q.d_erk_p  <= sat(sum_c_q[6]);
      out_q.d_erk_pp <= sat(sum_c_q[7]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[TotLat-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_ready_tracks_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("ready while stalled");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(vld_q) && out_valid_o))
    else $error("pipeline moved under stall");
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !vld_q[TotLat-1]) |=> !out_valid_o) else $error("result invented");
  a_mos_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.d_mos != -24'sd8388608 &&
     out_data_o.d_mos_p != -24'sd8388608) |->
    (out_data_o.d_mos == -out_data_o.d_mos_p)) else $error("Mos sum mismatch");

endmodule

// File: test/tb_mapk_cascade_rate_eval.sv
// Testbench for mapk_cascade_rate_eval: random and directed species vectors,
// a scoreboard that predicts the eight derivatives. Depends on mapk_pkg and the RTL.
`timescale 1ns / 1ps

// Scoreboard: holds the rate constants and the queue of predicted derivatives.
class mapk_rate_scoreboard;
  logic [23:0] consts [8];
  mapk_pkg::mapk_out_t pending_rates [$];
  int errors;

  function new();
    consts[0] = 24'd163840; consts[1] = 24'd589824; consts[2] = 24'd16384;
    consts[3] = 24'd1638;   consts[4] = 24'd49152;  consts[5] = 24'd1638;
    consts[6] = 24'd32768;  consts[7] = 24'd983040;
    errors = 0;
  endfunction

  function logic [127:0] quot(logic [127:0] n, logic [127:0] d);
    return (d == 0) ? 128'd0 : n / d;
  endfunction

  // Michaelis-Menten rate V*S/(K+S)
  function logic [127:0] mm_rate(logic [127:0] v, logic [127:0] s, logic [127:0] k);
    return quot(v * s, k + s);
  endfunction

  // Catalytic rate kc * E*S/(K+S), back to Q.16
  function logic [127:0] cat_rate(logic [127:0] kc, logic [127:0] e, logic [127:0] s,
                                  logic [127:0] k);
    return (kc * quot(e * s, k + s)) >> 16;
  endfunction

  function logic signed [23:0] clip(longint x);
    if (x > 64'sd8388607) return 24'sd8388607;
    if (x < -64'sd8388608) return -24'sd8388608;
    return x[23:0];
  endfunction

  function void note_request(mapk_pkg::mapk_in_t r);
    longint v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
    logic [127:0] km;
    mapk_pkg::mapk_out_t o;
    km = consts[7];
    v1 = longint'(quot(mm_rate(consts[0], r.mos, mapk_pkg::K1Const) * consts[1],
                       consts[1] + r.erk_pp));
    v2 = longint'(mm_rate(consts[2], r.mos_p, mapk_pkg::Kk2Const));
    v3 = longint'(cat_rate(consts[3], r.mos_p, r.mek, km));
    v4 = longint'(cat_rate(consts[3], r.mos_p, r.mek_p, km));
    v5 = longint'(mm_rate(consts[4], r.mek_pp, km));
    v6 = longint'(mm_rate(consts[4], r.mek_p, km));
    v7 = longint'(cat_rate(consts[5], r.mek_pp, r.erk, km));
    v8 = longint'(cat_rate(consts[5], r.mek_pp, r.erk_p, km));
    v9 = longint'(mm_rate(consts[6], r.erk_pp, km));
    v10 = longint'(mm_rate(consts[6], r.erk_p, km));
    o.d_mos = clip(v2 - v1);
    o.d_mos_p = clip(v1 - v2);
    o.d_mek = clip(v6 - v3);
    o.d_mek_p = clip(v3 - v4 + v5 - v6);
    o.d_mek_pp = clip(v4 - v5);
    o.d_erk = clip(v10 - v7);
    o.d_erk_p = clip(v7 - v8 + v9 - v10);
    o.d_erk_pp = clip(v8 - v9);
    pending_rates.push_back(o);
  endfunction

  function void check_rates(mapk_pkg::mapk_out_t got);
    mapk_pkg::mapk_out_t want;
    if (pending_rates.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending_rates.pop_front();
    if (got.d_mos !== want.d_mos) report("d_mos", want.d_mos, got.d_mos);
    if (got.d_mos_p !== want.d_mos_p) report("d_mos_p", want.d_mos_p, got.d_mos_p);
    if (got.d_mek !== want.d_mek) report("d_mek", want.d_mek, got.d_mek);
    if (got.d_mek_p !== want.d_mek_p) report("d_mek_p", want.d_mek_p, got.d_mek_p);
    if (got.d_mek_pp !== want.d_mek_pp) report("d_mek_pp", want.d_mek_pp, got.d_mek_pp);
    if (got.d_erk !== want.d_erk) report("d_erk", want.d_erk, got.d_erk);
    if (got.d_erk_p !== want.d_erk_p) report("d_erk_p", want.d_erk_p, got.d_erk_p);
    if (got.d_erk_pp !== want.d_erk_pp) report("d_erk_pp", want.d_erk_pp, got.d_erk_pp);
  endfunction

  function void report(string f, logic signed [23:0] want, logic signed [23:0] got);
    $display("%0t: %s expected %0d actual %0d", $time, f, want, got);
    errors++;
  endfunction
endclass

module tb_mapk_cascade_rate_eval;
  import mapk_pkg::*;

  localparam int Latency = 2 * NumW + 3;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mapk_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mapk_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  mapk_rate_scoreboard sb = new();
  longint cycle_count = 0;
  bit quiet_tail = 0;     // no idling in the last part of the run
  bit hold_drain = 0;     // long receiver hold-off requested

  mapk_cascade_rate_eval dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_mapk_cascade_rate_eval: errors");
      $finish;
    end
  end

  // Output side: check every accepted result; ready idles in bursts.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_rates(out_data_o);
      if (hold_drain) begin
        out_ready_i <= 1'b0;
        repeat (300) begin
          @(posedge clk_i);
        end
        hold_drain = 0;
        out_ready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Write one rate constant; only called while the pipeline is empty.
  // The enable drops again after each write.
  task automatic write_const(cfg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.consts[idx] = val;
    @(posedge clk_i);
  endtask

  // Offer one request and hold it until accepted; may idle first.
  task automatic send_request(mapk_in_t r);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // Wait until every predicted result has come back, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_rates.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  function automatic logic [InW-1:0] rand_conc();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return InW'($urandom_range(0, 1 << 20));   // around typical levels
      default: return InW'($urandom());
    endcase
  endfunction

  function automatic mapk_in_t rand_request();
    mapk_in_t r;
    r.mos = rand_conc(); r.mos_p = rand_conc(); r.mek = rand_conc();
    r.mek_p = rand_conc(); r.mek_pp = rand_conc(); r.erk = rand_conc();
    r.erk_p = rand_conc(); r.erk_pp = rand_conc();
    return r;
  endfunction

  function automatic logic [CfgW-1:0] rand_const(bit nonzero);
    logic [CfgW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = nonzero ? 24'd1 : 24'd0;
      1: v = '1;
      default: v = CfgW'($urandom());
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  initial begin
    mapk_in_t r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes at reset constants
    send_request('0);
    send_request('1);
    r = '0; r.mos = '1; send_request(r);
    r = '0; r.mos_p = '1; r.mek = '1; r.mek_p = '1; send_request(r);
    r = '0; r.mek_pp = '1; r.erk = '1; r.erk_p = '1; send_request(r);
    r = '0; r.erk_pp = '1; r.mos = 25'd655360; send_request(r);
    r = '1; r.erk_pp = '0; send_request(r);
    r = {8{25'h0AAAAAA}}; send_request(r);
    r = {8{25'h1555555}}; send_request(r);
    r = {8{25'd65536}}; send_request(r);
    drain();

    // Directed: all constants at maximum (saturation) then minimum
    for (int i = 0; i < NumCfg; i++) write_const(cfg_idx_e'(i), '1);
    send_request('1);
    r = '0; r.mos = '1; r.mos_p = 25'd1; send_request(r);
    r = '0; r.mos_p = '1; r.mek = '1; r.mek_pp = '1; r.erk = '1; send_request(r);
    r = '0; r.mek_p = '1; r.erk_p = '1; r.erk_pp = '1; send_request(r);
    drain();
    for (int i = 0; i < NumCfg; i++)
      write_const(cfg_idx_e'(i), (i == REG_FB_INHIB || i == REG_SHARED_KM) ? 24'd1 : 24'd0);
    send_request('1);
    send_request(rand_request());
    send_request(rand_request());
    drain();

    // Random phases, each with new constants
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NumCfg; i++)
        write_const(cfg_idx_e'(i),
                    rand_const(i == REG_FB_INHIB || i == REG_SHARED_KM));
      if (ph == 2) hold_drain = 1;   // stall the output so the pipe fills
      if (ph == 5) quiet_tail = 1;
      repeat (70) send_request(rand_request());
      drain();
    end

    // Back to the defaults for a last burst
    write_const(REG_MOS_ACT_VMAX, 24'd163840);
    write_const(REG_FB_INHIB, 24'd589824);
    write_const(REG_MOS_DEPH_VMAX, 24'd16384);
    write_const(REG_MEK_KCAT, 24'd1638);
    write_const(REG_MEK_DEPH_VMAX, 24'd49152);
    write_const(REG_ERK_KCAT, 24'd1638);
    write_const(REG_ERK_DEPH_VMAX, 24'd32768);
    write_const(REG_SHARED_KM, 24'd983040);
    repeat (20) send_request(rand_request());
    drain();

    if (sb.errors == 0 && sb.pending_rates.size() == 0) begin
      $display("tb_mapk_cascade_rate_eval: clean");
    end else begin
      $display("tb_mapk_cascade_rate_eval: errors");
    end
    $finish;
  end
endmodule
